@@ rtl/core/dvdd_pkg.sv @@
// Shared types, constants and calendar helpers for the date validate and
// day difference unit. No dependencies.
`default_nettype none

package dvdd_pkg;

  // Bounds for the time-of-day check
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;
  localparam logic [5:0] SECOND_MAX = 6'd59;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [8:0] YEAR_DAYS = 9'd365;

  // Reciprocals for exact floor division of a 14-bit value:
  // floor(x / 25)  = (x * RECIP_25)  >> RECIP_25_SHIFT
  // floor(x / 100) = (x * RECIP_100) >> RECIP_100_SHIFT
  localparam int unsigned  RECIP_25_SHIFT  = 24;
  localparam int unsigned  RECIP_100_SHIFT = 28;
  localparam logic [19:0]  RECIP_25        = 20'd671089;
  localparam logic [21:0]  RECIP_100       = 22'd2684355;

  // Day number of a zeroed date-time (year 0, month 0, day 0)
  localparam logic signed [23:0] DAYNUM_ZERO = -24'sd365;

  localparam logic [21:0] SPAN_MAX = 22'h3FFFFF;

  // Per-stage advance strobes handed to each date-time lane
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } dvdd_adv_t;

  // Days in the months before month m of a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd2:                   r = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default:                r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/dvdd_daynum.sv @@
// One date-time lane: validity checks and day number over three stages.
// Depends on dvdd_pkg.
`default_nettype none

module dvdd_daynum (
  input  logic                    clk,
  input  dvdd_pkg::dvdd_adv_t     adv,
  input  logic [13:0]             year,
  input  logic [3:0]              month,
  input  logic [4:0]              day,
  input  logic [4:0]              hour,
  input  logic [5:0]              minute,
  input  logic [5:0]              second,
  output logic                    date_ok,
  output logic                    time_ok,
  output logic signed [23:0]      day_num
);

  // ---------------- stage 1: reciprocal multiplies ----------------
  logic [13:0] xm;
  logic [33:0] prod25;
  logic [35:0] prod100;
  logic [22:0] x365;

  assign xm      = year - 14'd1;
  assign prod25  = 34'(year) * 34'(dvdd_pkg::RECIP_25);
  assign prod100 = 36'(xm) * 36'(dvdd_pkg::RECIP_100);
  assign x365    = 23'(xm) * 23'(dvdd_pkg::YEAR_DAYS);

  logic [13:0] y1_r;
  logic [3:0]  m1_r;
  logic [4:0]  d1_r;
  logic        tok1_r;
  logic [9:0]  q25_1_r;
  logic [7:0]  q100_1_r;
  logic [22:0] x365_1_r;
  logic [11:0] xq4_1_r;

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      y1_r     <= year;
      m1_r     <= month;
      d1_r     <= day;
      tok1_r   <= (hour <= dvdd_pkg::HOUR_MAX) && (minute <= dvdd_pkg::MINUTE_MAX) &&
                  (second <= dvdd_pkg::SECOND_MAX);
      q25_1_r  <= prod25[dvdd_pkg::RECIP_25_SHIFT +: 10];
      q100_1_r <= prod100[dvdd_pkg::RECIP_100_SHIFT +: 8];
      x365_1_r <= x365;
      xq4_1_r  <= xm[13:2];
    end
  end

  // ---------------- stage 2: leap rule, date check, partial sums ----------------
  logic [13:0] mul25;
  logic        div25;
  logic        leap;
  logic        dok;
  logic [8:0]  cum;

  assign mul25 = 14'(q25_1_r) * 14'd25;
  assign div25 = (mul25 == y1_r);
  // divisible by 4 and not by 100, or divisible by 400
  assign leap  = (y1_r[1:0] == 2'd0) && (!div25 || (y1_r[3:0] == 4'd0));
  assign dok   = (m1_r >= dvdd_pkg::MONTH_JAN) && (m1_r <= dvdd_pkg::MONTH_DEC) &&
                 (d1_r != 5'd0) && (d1_r <= dvdd_pkg::month_len(m1_r, leap));
  assign cum   = dvdd_pkg::cum_days(m1_r) +
                 9'((leap && (m1_r > dvdd_pkg::MONTH_FEB)) ? 1 : 0) + 9'(d1_r);

  logic        dok2_r;
  logic        tok2_r;
  logic        yz2_r;
  logic [22:0] base2_r;
  logic [7:0]  corr2_r;
  logic [8:0]  cum2_r;

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      dok2_r  <= dok;
      tok2_r  <= tok1_r;
      yz2_r   <= (y1_r == 14'd0);
      base2_r <= x365_1_r + 23'(xq4_1_r);
      corr2_r <= q100_1_r - {2'b00, q100_1_r[7:2]};
      cum2_r  <= cum;
    end
  end

  // ---------------- stage 3: final day number ----------------
  logic signed [23:0] n_sel;

  always_comb begin
    if (!(dok2_r && tok2_r)) begin
      n_sel = dvdd_pkg::DAYNUM_ZERO;
    end else if (yz2_r) begin
      // year zero: quotients of minus one are zero
      n_sel = dvdd_pkg::DAYNUM_ZERO + $signed({15'd0, cum2_r});
    end else begin
      n_sel = $signed({1'b0, base2_r}) - $signed({16'd0, corr2_r}) +
              $signed({15'd0, cum2_r});
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      date_ok <= dok2_r;
      time_ok <= tok2_r;
      day_num <= n_sel;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/date_validate_and_day_difference_unit.sv @@
// Top level of the date validate and day difference unit.
// Depends on dvdd_pkg and dvdd_daynum.
`default_nettype none

// Channel  Dir  Width  Beat contents
// in_      in   80     two date-times A and B (year, month, day, hour, min, sec)
// out_     out  32     four check flags and the absolute day span
//
// An input beat is taken every cycle unless an output stall fills the
// pipeline. Stages: reciprocal multiplies, leap rule and date
// check, day number sum, then difference with saturation into the output
// register. Each stage holds a valid bit and advances whenever the stage
// after it is empty or moving, so bubbles collapse under an output stall.
// Reset clears the valid bits only; the unit keeps no other state.

module date_validate_and_day_difference_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [13:0] year_a, [17:14] month_a, [22:18] day_a, [27:23] hour_a,
  // [33:28] minute_a, [39:34] second_a, [53:40] year_b, [57:54] month_b,
  // [62:58] day_b, [67:63] hour_b, [73:68] minute_b, [79:74] second_b
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] date_ok_a, [1] time_ok_a, [2] date_ok_b, [3] time_ok_b,
  // [25:4] day_span, [31:26] zero
  output logic [31:0] out_tdata
);

  logic v1_r, v2_r, v3_r, vo_r;
  logic v1_nxt, v2_nxt, v3_nxt, vo_nxt;
  logic adv_o;
  dvdd_pkg::dvdd_adv_t adv;

  // Advance a stage when the next one is empty or moving
  assign adv_o  = !vo_r || out_tready;
  assign adv.s3 = !v3_r || adv_o;
  assign adv.s2 = !v2_r || adv.s3;
  assign adv.s1 = !v1_r || adv.s2;
  assign in_tready = adv.s1;

  assign v1_nxt = adv.s1 ? in_tvalid : v1_r;
  assign v2_nxt = adv.s2 ? v1_r : v2_r;
  assign v3_nxt = adv.s3 ? v2_r : v3_r;
  assign vo_nxt = adv_o  ? v3_r : vo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      vo_r <= vo_nxt;
    end
  end

  // Two independent lanes, one per date-time
  logic               dok_a, tok_a, dok_b, tok_b;
  logic signed [23:0] num_a, num_b;

  dvdd_daynum u_lane_a (
    .clk     (clk),
    .adv     (adv),
    .year    (in_tdata[13:0]),
    .month   (in_tdata[17:14]),
    .day     (in_tdata[22:18]),
    .hour    (in_tdata[27:23]),
    .minute  (in_tdata[33:28]),
    .second  (in_tdata[39:34]),
    .date_ok (dok_a),
    .time_ok (tok_a),
    .day_num (num_a)
  );

  dvdd_daynum u_lane_b (
    .clk     (clk),
    .adv     (adv),
    .year    (in_tdata[53:40]),
    .month   (in_tdata[57:54]),
    .day     (in_tdata[62:58]),
    .hour    (in_tdata[67:63]),
    .minute  (in_tdata[73:68]),
    .second  (in_tdata[79:74]),
    .date_ok (dok_b),
    .time_ok (tok_b),
    .day_num (num_b)
  );

  // Absolute difference; saturate to the span field width
  logic [23:0] mag;
  logic [21:0] span;

  assign mag  = (num_a >= num_b) ? 24'(num_a - num_b) : 24'(num_b - num_a);
  assign span = (mag > 24'(dvdd_pkg::SPAN_MAX)) ? dvdd_pkg::SPAN_MAX : mag[21:0];

  logic [31:0] out_data_r;

  always_ff @(posedge clk) begin
    if (adv_o) begin
      out_data_r <= {6'd0, span, tok_b, dok_b, tok_a, dok_a};
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = out_data_r;

  // ---------------- assertions ----------------

  // Input is held off only while every stage holds a beat
  a_ready_only_when_full: assert property (
    @(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r && vo_r)
  ) else $error("input stalled with a free pipeline slot");

  // Two rejected date-times both map to the zero day number
  a_both_invalid_zero_span: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && !(out_tdata[0] && out_tdata[1]) && !(out_tdata[2] && out_tdata[3]))
      |-> (out_tdata[25:4] == 22'd0)
  ) else $error("nonzero span between two invalid date-times");

  // A beat taken into a full output stage comes from stage three
  a_output_load: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !v3_r) |=> !out_tvalid
  ) else $error("result appeared without a stage three beat");

  a_reset_clears: assert property (
    @(posedge clk) !rst_n |=> !out_tvalid
  ) else $error("output valid after reset");

endmodule

`default_nettype wire

@@ bench/tb_date_validate_and_day_difference_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for date_validate_and_day_difference_unit: a table of
// calendar corner cases, then random date pairs under bursty, stalled traffic.
// Depends on dvdd_pkg and the unit RTL only.

module tb_date_validate_and_day_difference_unit;

  localparam int unsigned RANDOM_PAIRS = 1300;
  localparam int unsigned IDLE_LIMIT   = 2000;  // cycles without any beat
  localparam int unsigned DRAIN_CYCLES = 16;    // settle time after last result
  localparam int unsigned SHOWN_MAX    = 10;
  localparam longint      SPAN_CEILING = longint'(dvdd_pkg::SPAN_MAX);

  // One date-time as it sits in 40 bits of in_tdata, year in the lowest bits
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } stamp_t;

  // Full input beat: A in [39:0], B in [79:40]
  typedef struct packed {
    stamp_t b;
    stamp_t a;
  } date_pair_t;

  // Result beat, date_ok_a in bit 0
  typedef struct packed {
    logic [5:0]  pad;
    logic [21:0] day_span;
    logic        time_ok_b;
    logic        date_ok_b;
    logic        time_ok_a;
    logic        date_ok_a;
  } span_result_t;

  typedef struct {
    date_pair_t   pair;
    bit           typed;  // want was written by hand, skip the predictor
    span_result_t want;
  } corner_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [79:0] in_tdata   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;

  span_result_t pending_spans[$];  // expected results, oldest first
  corner_row_t  corner_rows[$];
  bit           row_typed       = 1'b0;
  span_result_t row_want        = '0;
  int unsigned  span_mismatches = 0;
  int unsigned  quiet_cycles    = 0;
  int unsigned  burst_left      = 0;
  logic [8:0]   rx_cycle        = '0;

  always #5 clk = ~clk;

  date_validate_and_day_difference_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // ---------------------------------------------------------------------------
  // Calendar predictor. All arithmetic is signed 64-bit so that year zero
  // gives (year-1) = -1 and the quotients truncate toward zero.
  // ---------------------------------------------------------------------------
  function automatic bit leap_year(input longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint month_days(input longint y, input longint m);
    if (m == longint'(dvdd_pkg::MONTH_FEB)) return leap_year(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic bit date_valid(input stamp_t s);
    if (s.month < dvdd_pkg::MONTH_JAN || s.month > dvdd_pkg::MONTH_DEC) return 1'b0;
    if (s.day == 5'd0) return 1'b0;
    return longint'(s.day) <= month_days(longint'(s.year), longint'(s.month));
  endfunction

  function automatic bit time_valid(input stamp_t s);
    return s.hour <= dvdd_pkg::HOUR_MAX && s.minute <= dvdd_pkg::MINUTE_MAX &&
           s.second <= dvdd_pkg::SECOND_MAX;
  endfunction

  function automatic longint day_index(input longint y, input longint m, input longint d);
    longint x;
    longint n;
    x = y - 1;
    n = x * 365 + x / 4 - x / 100 + x / 400 + d;
    for (longint k = 1; k < m && k <= 12; k++)
      n += month_days(y, k);
    return n;
  endfunction

  function automatic span_result_t predict_span(input date_pair_t p);
    span_result_t r;
    longint na;
    longint nb;
    longint diff;
    r = '0;
    r.date_ok_a = date_valid(p.a);
    r.time_ok_a = time_valid(p.a);
    r.date_ok_b = date_valid(p.b);
    r.time_ok_b = time_valid(p.b);
    // A side that fails either check counts as the all-zero date
    na = (r.date_ok_a && r.time_ok_a) ? day_index(p.a.year, p.a.month, p.a.day)
                                      : day_index(0, 0, 0);
    nb = (r.date_ok_b && r.time_ok_b) ? day_index(p.b.year, p.b.month, p.b.day)
                                      : day_index(0, 0, 0);
    diff = (na >= nb) ? na - nb : nb - na;
    if (diff > SPAN_CEILING) diff = SPAN_CEILING;
    r.day_span = diff[21:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic stamp_t stamp(input int unsigned y, input int unsigned m,
                                   input int unsigned d, input int unsigned h,
                                   input int unsigned mi, input int unsigned s);
    stamp_t t;
    t.year   = y[13:0];
    t.month  = m[3:0];
    t.day    = d[4:0];
    t.hour   = h[4:0];
    t.minute = mi[5:0];
    t.second = s[5:0];
    return t;
  endfunction

  function automatic span_result_t result_of(input bit dok_a, input bit tok_a,
                                             input bit dok_b, input bit tok_b,
                                             input int unsigned span);
    span_result_t r;
    r           = '0;
    r.date_ok_a = dok_a;
    r.time_ok_a = tok_a;
    r.date_ok_b = dok_b;
    r.time_ok_b = tok_b;
    r.day_span  = span[21:0];
    return r;
  endfunction

  function automatic void add_corner(input stamp_t a, input stamp_t b, input bit typed,
                                     input span_result_t want);
    corner_row_t row;
    row.pair.a = a;
    row.pair.b = b;
    row.typed  = typed;
    row.want   = want;
    corner_rows.push_back(row);
  endfunction

  // Mostly well-formed date-times, biased toward century and leap years,
  // with a share of edge values and a share of raw random bits.
  function automatic stamp_t random_stamp();
    stamp_t      s;
    logic [63:0] raw;
    int unsigned kind;
    int unsigned pick;
    kind = $urandom_range(0, 99);
    pick = $urandom_range(0, 9);
    raw  = {$urandom(), $urandom()};
    if (kind >= 88) return raw[39:0];
    case (pick)
      0:       s.year = 14'($urandom_range(0, 4));
      1:       s.year = 14'(100 * $urandom_range(0, 99));
      2:       s.year = 14'(400 * $urandom_range(0, 40));
      3:       s.year = 14'($urandom_range(10000, 16383));
      4:       s.year = 14'd16383;
      default: s.year = 14'($urandom_range(1, 9999));
    endcase
    s.month = 4'($urandom_range(1, 12));
    if (kind < 70) begin
      s.day    = 5'($urandom_range(1, int'(month_days(s.year, s.month))));
      s.hour   = 5'($urandom_range(0, 23));
      s.minute = 6'($urandom_range(0, 59));
      s.second = 6'($urandom_range(0, 59));
    end else begin
      // Last day of the month or one past it; times around the limits
      s.day    = 5'(month_days(s.year, s.month) + longint'($urandom_range(0, 1)));
      s.hour   = 5'($urandom_range(21, 25));
      s.minute = 6'($urandom_range(57, 61));
      s.second = 6'($urandom_range(57, 61));
    end
    return s;
  endfunction

  // Drive one beat at the falling edge and hold it until accepted. Each burst
  // starts with a random gap in which valid is dropped.
  task automatic send_pair(input date_pair_t p, input bit typed, input span_result_t want);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 24);
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    row_typed = typed;
    row_want  = want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid and hold off until every expected result has come back
  task automatic wait_for_drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_spans.size() != 0) @(negedge clk);
  endtask

  function automatic void note_mismatch(input string what, input span_result_t want,
                                        input span_result_t got);
    span_mismatches++;
    if (span_mismatches <= SHOWN_MAX)
      $display("%0t %s: expected ok=%b%b%b%b span=%0d pad=%h, got ok=%b%b%b%b span=%0d pad=%h",
               $realtime, what, want.date_ok_a, want.time_ok_a, want.date_ok_b,
               want.time_ok_b, want.day_span, want.pad, got.date_ok_a, got.time_ok_a,
               got.date_ok_b, got.time_ok_b, got.day_span, got.pad);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: cycle through ready patterns of its own, from always ready to
  // long stalls.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 9'd1;
    case (rx_cycle[8:6])
      3'd0, 3'd1: out_tready <= 1'b1;
      3'd2:       out_tready <= (rx_cycle[1:0] != 2'd3);
      3'd3, 3'd4: out_tready <= ($urandom_range(0, 3) != 0);
      3'd5:       out_tready <= rx_cycle[3];
      3'd6:       out_tready <= ($urandom_range(0, 1) == 1);
      default:    out_tready <= (rx_cycle[4:0] > 5'd20);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard: sample both channels at the rising edge. Check the
  // result beat before queueing the new input so an early stray result is
  // never matched against the beat accepted in the same cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    span_result_t got;
    span_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = span_result_t'(out_tdata);
        if (pending_spans.size() == 0) begin
          note_mismatch("result beat with nothing expected", '0, got);
        end else begin
          want = pending_spans.pop_front();
          if (got.date_ok_a !== want.date_ok_a || got.time_ok_a !== want.time_ok_a ||
              got.date_ok_b !== want.date_ok_b || got.time_ok_b !== want.time_ok_b ||
              got.day_span !== want.day_span || got.pad !== want.pad)
            note_mismatch("result mismatch", want, got);
        end
      end
      if (in_tvalid && in_tready)
        pending_spans.push_back(row_typed ? row_want : predict_span(date_pair_t'(in_tdata)));

      // Watchdog: advance only while neither channel moves a beat
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("date_validate_and_day_difference_unit test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    date_pair_t p;

    // Hand-checked rows: all-zero and all-ones fields, identical dates,
    // one day apart, a bad time against the zeroed date (-365 vs day 1)
    add_corner(stamp(0, 0, 0, 0, 0, 0), stamp(0, 0, 0, 0, 0, 0), 1'b1,
               result_of(1'b0, 1'b1, 1'b0, 1'b1, 0));
    add_corner(stamp(16383, 15, 31, 31, 63, 63), stamp(16383, 15, 31, 31, 63, 63), 1'b1,
               result_of(1'b0, 1'b0, 1'b0, 1'b0, 0));
    add_corner(stamp(1, 1, 1, 0, 0, 0), stamp(1, 1, 1, 23, 59, 59), 1'b1,
               result_of(1'b1, 1'b1, 1'b1, 1'b1, 0));
    add_corner(stamp(1, 1, 1, 0, 0, 0), stamp(1, 1, 2, 12, 30, 30), 1'b1,
               result_of(1'b1, 1'b1, 1'b1, 1'b1, 1));
    add_corner(stamp(1, 1, 1, 0, 0, 0), stamp(1, 1, 1, 24, 0, 0), 1'b1,
               result_of(1'b1, 1'b1, 1'b1, 1'b0, 366));
    add_corner(stamp(1, 1, 1, 0, 60, 0), stamp(1, 1, 1, 0, 0, 60), 1'b1,
               result_of(1'b1, 1'b0, 1'b1, 1'b0, 0));

    // Predictor rows: leap rule by 400, 100 and 4, month lengths, day zero,
    // month 13, year zero, widest spans and span saturation
    add_corner(stamp(2000, 2, 29, 8, 0, 0), stamp(1900, 2, 29, 8, 0, 0), 1'b0, '0);
    add_corner(stamp(2004, 2, 29, 0, 0, 0), stamp(2001, 2, 29, 0, 0, 0), 1'b0, '0);
    add_corner(stamp(2023, 2, 28, 1, 2, 3), stamp(2023, 2, 30, 1, 2, 3), 1'b0, '0);
    add_corner(stamp(2023, 4, 31, 5, 5, 5), stamp(2023, 4, 30, 5, 5, 5), 1'b0, '0);
    add_corner(stamp(2023, 6, 0, 0, 0, 0), stamp(2023, 9, 31, 0, 0, 0), 1'b0, '0);
    add_corner(stamp(2023, 13, 1, 0, 0, 0), stamp(2023, 11, 30, 0, 0, 0), 1'b0, '0);
    add_corner(stamp(0, 1, 1, 0, 0, 0), stamp(0, 2, 29, 0, 0, 0), 1'b0, '0);
    add_corner(stamp(0, 12, 31, 0, 0, 0), stamp(1, 1, 1, 0, 0, 0), 1'b0, '0);
    add_corner(stamp(9999, 12, 31, 23, 59, 59), stamp(1, 1, 1, 0, 0, 0), 1'b0, '0);
    add_corner(stamp(16383, 12, 31, 0, 0, 0), stamp(0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_corner(stamp(16383, 12, 31, 0, 0, 0), stamp(9999, 12, 31, 0, 0, 0), 1'b0, '0);
    add_corner(stamp(2024, 1, 31, 0, 0, 0), stamp(2024, 3, 1, 0, 0, 0), 1'b0, '0);
    add_corner(stamp(2100, 2, 29, 0, 0, 0), stamp(2400, 2, 29, 0, 0, 0), 1'b0, '0);
    add_corner(stamp(1970, 1, 1, 31, 59, 59), stamp(1970, 1, 1, 23, 63, 59), 1'b0, '0);
    add_corner(stamp(8191, 7, 31, 12, 0, 0), stamp(4096, 8, 31, 12, 0, 0), 1'b0, '0);

    // Hold reset, then release it at a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (corner_rows[i])
      send_pair(corner_rows[i].pair, corner_rows[i].typed, corner_rows[i].want);
    wait_for_drain();

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      if (n % 400 == 399) wait_for_drain();
      p.a = random_stamp();
      if ($urandom_range(0, 4) == 0) begin
        // Nearby second date: same month and year, random day
        p.b     = p.a;
        p.b.day = 5'($urandom_range(0, 31));
      end else begin
        p.b = random_stamp();
      end
      send_pair(p, 1'b0, '0);
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (span_mismatches == 0)
      $display("date_validate_and_day_difference_unit test passed");
    else
      $display("date_validate_and_day_difference_unit test failed");
    $finish;
  end

endmodule
